// ===== src/b64e_pkg.sv =====
// shared types, constants and the alphabet lookup for the base64 encoder
package b64e_pkg;

  localparam int unsigned CharW     = 7;
  localparam int unsigned SlotsMax  = 4;
  localparam int unsigned SlotIdxW  = 2;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  localparam logic [CharW-1:0] PadChar = 7'h3D;

  // byte position within its group of three
  localparam logic [1:0] PhaseFirst  = 2'd0;
  localparam logic [1:0] PhaseSecond = 2'd1;
  localparam logic [1:0] PhaseThird  = 2'd2;

  typedef logic [CharW-1:0] char_t;

  // one decoded input byte: up to four characters and how many to send
  typedef struct packed {
    char_t [SlotsMax-1:0] chars;
    logic [SlotIdxW-1:0]  last_idx;
    logic                 fin;
  } b64e_job_t;

  // map a six-bit group to its standard alphabet character
  function automatic char_t b64e_sextet_char(input logic [5:0] v);
    char_t vx;
    char_t res;
    vx = {1'b0, v};
    if (v < 6'd26) begin
      res = vx + 7'h41;
    end else if (v < 6'd52) begin
      res = vx + 7'h47;
    end else if (v < 6'd62) begin
      res = vx - 7'h04;
    end else if (v == 6'd62) begin
      res = 7'h2B;
    end else begin
      res = 7'h2F;
    end
    return res;
  endfunction

endpackage

// ===== src/b64e_if.sv =====
// stream channel interfaces for message bytes and encoded characters
interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       run_last;
  logic       message_end;

  modport source (output valid, output out_char, output run_last, output message_end,
                  input ready);
  modport sink   (input valid, input out_char, input run_last, input message_end,
                  output ready);
endinterface

// ===== src/b64e_front.sv =====
// front end: accepts bytes, tracks group phase and leftover bits, builds jobs
module b64e_front import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  b64e_in_if.sink    in_bus,
  output logic       job_valid,
  input  logic       job_ready,
  output b64e_job_t  job
);

  logic [3:0] left_r, left_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       accept;
  logic [7:0] b;
  logic       fin;

  assign b         = in_bus.data_byte;
  assign fin       = in_bus.final_byte;
  assign in_bus.ready = job_ready;
  assign job_valid = in_bus.valid;
  assign accept    = in_bus.valid && job_ready;

  // classify the byte by its phase and form the characters it causes
  always_comb begin
    job.chars    = '{default: PadChar};
    job.last_idx = 2'd0;
    job.fin      = fin;
    left_nxt     = left_r;
    phase_nxt    = phase_r;
    unique case (phase_r)
      PhaseSecond: begin
        job.chars[0] = b64e_sextet_char({left_r[1:0], b[7:4]});
        if (fin) begin
          job.chars[1] = b64e_sextet_char({b[3:0], 2'b00});
          job.last_idx = 2'd2;
        end
        left_nxt  = b[3:0];
        phase_nxt = PhaseThird;
      end
      PhaseThird: begin
        job.chars[0] = b64e_sextet_char({left_r, b[7:6]});
        job.chars[1] = b64e_sextet_char(b[5:0]);
        job.last_idx = 2'd1;
        left_nxt     = 4'd0;
        phase_nxt    = PhaseFirst;
      end
      default: begin
        job.chars[0] = b64e_sextet_char(b[7:2]);
        if (fin) begin
          job.chars[1] = b64e_sextet_char({b[1:0], 4'b0000});
          job.last_idx = 2'd3;
        end
        left_nxt  = {2'b00, b[1:0]};
        phase_nxt = PhaseSecond;
      end
    endcase
    // end of message starts a fresh group
    if (fin) begin
      left_nxt  = 4'd0;
      phase_nxt = PhaseFirst;
    end
  end

  // phase and leftover state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= 4'd0;
      phase_r <= PhaseFirst;
    end else if (accept) begin
      left_r  <= left_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== src/b64e_queue.sv =====
// short job queue between front and back ends
module b64e_queue import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  b64e_job_t  push_job,
  output logic       pop_valid,
  input  logic       pop_ready,
  output b64e_job_t  pop_job
);

  b64e_job_t             slots_r [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QueueCntW-1:0]  count_r;
  logic                  do_push, do_pop;

  assign push_ready = (count_r != QueueCntW'(QueueDepth));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/b64e_back.sv =====
// back end: walks each job's characters and drives the output register
module b64e_back import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  output logic       job_ready,
  input  b64e_job_t  job,
  b64e_out_if.source out_bus
);

  logic [SlotIdxW-1:0] idx_r;
  logic                out_valid_r;
  char_t               out_char_r;
  logic                run_last_r;
  logic                message_end_r;
  logic                load;
  logic                is_last;

  assign load      = job_valid && (!out_valid_r || out_bus.ready);
  assign is_last   = (idx_r == job.last_idx);
  assign job_ready = load && is_last;

  assign out_bus.valid       = out_valid_r;
  assign out_bus.out_char    = out_char_r;
  assign out_bus.run_last    = run_last_r;
  assign out_bus.message_end = message_end_r;

  // character index within the current job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (load) begin
      idx_r <= is_last ? '0 : idx_r + 1'b1;
    end
  end

  // output beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r    <= job.chars[idx_r];
      run_last_r    <= is_last;
      message_end_r <= is_last && job.fin;
    end
  end

endmodule

// ===== src/base64_encoder.sv =====
// top level of the streaming base64 encoder
// Streaming base64 encoder, standard alphabet with '=' padding. One message
// byte is taken per beat on in_bus, with final_byte set on the last byte of a
// message; every message must have at least one byte. Each byte yields one to
// four characters on out_bus, one character per clock while out_bus is ready:
// run_last marks the last character of a byte and message_end the last
// character of the message. A byte is taken into a two-entry job queue, so
// input and output stall independently; sustained rate is set by the single
// output register at one character per cycle while out_bus is ready, with the
// final byte of a message adding its flush and padding characters.
module base64_encoder import b64e_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  b64e_in_if.sink     in_bus,
  b64e_out_if.source  out_bus
);

  logic      push_valid, push_ready;
  logic      pop_valid, pop_ready;
  b64e_job_t push_job, pop_job;

  b64e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .job_valid (push_valid),
    .job_ready (push_ready),
    .job       (push_job)
  );

  b64e_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job       (pop_job),
    .out_bus   (out_bus)
  );

endmodule

// ===== tb/base64_encoder_check.sv =====
// beat monitor, character predictor and scoreboard for the base64 encoder
`timescale 1ns / 1ps

module base64_encoder_check import b64e_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  b64e_in_if          in_bus,
  b64e_out_if         out_bus,
  output int unsigned error_count,
  output int unsigned chars_pending
);

  localparam logic [7:0] AsciiUpperA = 8'h41;
  localparam logic [7:0] AsciiLowerA = 8'h61;
  localparam logic [7:0] AsciiZero   = 8'h30;
  localparam logic [7:0] AsciiPlus   = 8'h2B;
  localparam logic [7:0] AsciiSlash  = 8'h2F;

  typedef struct packed {
    char_t ch;
    logic  run_last;
    logic  msg_end;
  } enc_char_t;

  // encoder state as the block should hold it
  logic [3:0] carry_bits;
  logic [1:0] group_pos;

  // characters owed by the block, oldest first
  enc_char_t owed_chars[$];

  // six-bit group to its alphabet character
  function automatic char_t alpha_char(input logic [5:0] v);
    logic [7:0] code;
    if (v < 6'd26) begin
      code = AsciiUpperA + {2'b00, v};
    end else if (v < 6'd52) begin
      code = AsciiLowerA + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      code = AsciiZero + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      code = AsciiPlus;
    end else begin
      code = AsciiSlash;
    end
    return code[6:0];
  endfunction

  function automatic enc_char_t plain(input char_t c);
    enc_char_t e;
    e.ch = c;
    e.run_last = 1'b0;
    e.msg_end = 1'b0;
    return e;
  endfunction

  // work out the characters one message byte causes and advance the state
  task automatic predict_chars(input logic [7:0] b, input logic fin);
    enc_char_t run [SlotsMax];
    int n;
    n = 0;
    case (group_pos)
      PhaseSecond: begin
        run[0] = plain(alpha_char({carry_bits[1:0], b[7:4]}));
        n = 1;
        carry_bits = b[3:0];
        if (fin) begin
          run[1] = plain(alpha_char({carry_bits, 2'b00}));
          run[2] = plain(PadChar);
          n = 3;
        end
        group_pos = PhaseThird;
      end
      PhaseThird: begin
        run[0] = plain(alpha_char({carry_bits, b[7:6]}));
        run[1] = plain(alpha_char(b[5:0]));
        n = 2;
        carry_bits = 4'd0;
        group_pos = PhaseFirst;
      end
      default: begin
        run[0] = plain(alpha_char(b[7:2]));
        n = 1;
        carry_bits = {2'b00, b[1:0]};
        if (fin) begin
          run[1] = plain(alpha_char({b[1:0], 4'b0000}));
          run[2] = plain(PadChar);
          run[3] = plain(PadChar);
          n = 4;
        end
        group_pos = PhaseSecond;
      end
    endcase
    run[n-1].run_last = 1'b1;
    if (fin) begin
      run[n-1].msg_end = 1'b1;
      carry_bits = 4'd0;
      group_pos = PhaseFirst;
    end
    for (int i = 0; i < n; i++) owed_chars = {owed_chars, run[i]};
  endtask

  // watch both channels at each rising edge
  always @(posedge clk) begin
    enc_char_t got;
    enc_char_t want;
    if (!rst_n) begin
      carry_bits = 4'd0;
      group_pos = PhaseFirst;
      error_count = 0;
      owed_chars.delete();
    end else begin
      // input beat
      if (in_bus.valid && in_bus.ready) predict_chars(in_bus.data_byte, in_bus.final_byte);
      // output beat
      if (out_bus.valid && out_bus.ready) begin
        got.ch = out_bus.out_char;
        got.run_last = out_bus.run_last;
        got.msg_end = out_bus.message_end;
        if (owed_chars.size() == 0) begin
          $display("%0t: unexpected char: got char=%h run_last=%b message_end=%b",
                   $time, got.ch, got.run_last, got.msg_end);
          error_count = error_count + 1;
        end else begin
          want = owed_chars.pop_front();
          if (got !== want) begin
            $display({"%0t: mismatch: expected char=%h run_last=%b message_end=%b,",
                      " got char=%h run_last=%b message_end=%b"},
                     $time, want.ch, want.run_last, want.msg_end,
                     got.ch, got.run_last, got.msg_end);
            error_count = error_count + 1;
          end
        end
      end
    end
    chars_pending = owed_chars.size();
  end

endmodule

// ===== tb/base64_encoder_test.sv =====
// stimulus, reset, clock and verdict for the base64 encoder
`timescale 1ns / 1ps

module base64_encoder_test;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold   = 120;

  logic clk;
  logic rst_n;
  logic idle_on;
  logic long_hold_req;
  logic long_hold_used = 1'b0;
  int unsigned error_count;
  int unsigned chars_pending;
  int unsigned bytes_sent;
  int unsigned cycle_count = 0;
  int sink_hold = 0;

  b64e_in_if  in_bus ();
  b64e_out_if out_bus ();

  base64_encoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  base64_encoder_check check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_bus        (in_bus),
    .out_bus       (out_bus),
    .error_count   (error_count),
    .chars_pending (chars_pending)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stall bursts plus one long hold-off on request
  always @(negedge clk) begin
    if (long_hold_req && !long_hold_used) begin
      long_hold_used = 1'b1;
      sink_hold = LongHold;
    end
    if (sink_hold > 0) begin
      out_bus.ready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_bus.ready <= 1'b0;
      sink_hold = $urandom_range(0, 9);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // offer one byte and hold it until the beat is taken
  task automatic send_beat(input logic [7:0] b, input logic fin);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.final_byte <= fin;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    bytes_sent = bytes_sent + 1;
    @(negedge clk);
  endtask

  // one message of random bytes, mostly short
  task automatic send_random_message();
    int len;
    if ($urandom_range(0, 1) == 0) len = $urandom_range(1, 3);
    else len = $urandom_range(1, 16);
    for (int i = 0; i < len; i++) send_beat(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // settle the input, then change the idling mode at a rising edge
  task automatic set_idling(input logic on, input logic hold);
    in_bus.valid <= 1'b0;
    @(posedge clk);
    idle_on = on;
    long_hold_req = hold;
    @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    idle_on = 1'b0;
    long_hold_req = 1'b0;
    bytes_sent = 0;
    in_bus.valid = 1'b0;
    in_bus.data_byte = 8'h00;
    in_bus.final_byte = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: one-byte messages at both extremes (double padding)
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b1);
    // two-byte message (single padding)
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);
    // full groups, no padding, with '+' and '/'
    send_beat(8'hFB, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hBF, 1'b1);
    send_beat(8'h4D, 1'b0);
    send_beat(8'h61, 1'b0);
    send_beat(8'h6E, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);
    // messages running past one group, ending on the first and second byte of a group
    send_beat(8'h10, 1'b0);
    send_beat(8'h20, 1'b0);
    send_beat(8'h30, 1'b0);
    send_beat(8'h40, 1'b1);
    send_beat(8'hA5, 1'b0);
    send_beat(8'h5A, 1'b0);
    send_beat(8'hC3, 1'b0);
    send_beat(8'h3C, 1'b0);
    send_beat(8'h99, 1'b1);
    in_bus.valid <= 1'b0;
    while (chars_pending != 0) @(negedge clk);

    // random messages with idling on both sides and one long receiver hold-off
    set_idling(1'b1, 1'b1);
    while (bytes_sent < 250) send_random_message();

    // closing stretch with no idling
    set_idling(1'b0, 1'b0);
    while (bytes_sent < 310) send_random_message();
    in_bus.valid <= 1'b0;

    while (chars_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
